[rtl/core/fsde_pkg.sv]
// package: screen geometry, command codes, segment table and shared types
package fsde_pkg;
  localparam int SCREEN_COLUMNS = 240;
  localparam int SCREEN_ROWS = 320;
  localparam int SEGMENT_PADDING = 2;
  localparam int FRAME_SIZE = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(FRAME_SIZE);
  localparam int CRD_W = 12;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_HLINE = 3'd1;
  localparam logic [2:0] CMD_VLINE = 3'd2;
  localparam logic [2:0] CMD_OUTLINE = 3'd3;
  localparam logic [2:0] CMD_FILL = 3'd4;
  localparam logic [2:0] CMD_DIGIT = 3'd5;
  localparam logic [2:0] CMD_READ = 3'd6;

  localparam logic [3:0] DIGIT_SOLID = 4'd10;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_req_t;

  function automatic logic [6:0] seg_mask(input logic [3:0] d);
    logic [6:0] m;
    unique case (d)
      4'd0: m = 7'h3F;
      4'd1: m = 7'h06;
      4'd2: m = 7'h5B;
      4'd3: m = 7'h4F;
      4'd4: m = 7'h66;
      4'd5: m = 7'h6D;
      4'd6: m = 7'h7D;
      4'd7: m = 7'h07;
      4'd8: m = 7'h7F;
      4'd9: m = 7'h6F;
      default: m = 7'h00;
    endcase
    return m;
  endfunction
endpackage

[rtl/core/fsde_frame_mem.sv]
// frame store: one write and one registered read a cycle, both at the one request address
module fsde_frame_mem
  import fsde_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);
  logic [7:0] mem [FRAME_SIZE];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.data;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end
endmodule

[rtl/core/fsde_plot.sv]
// plot unit: bounds check and address generation for one pixel
module fsde_plot
  import fsde_pkg::*;
(
  input  crd_t              x,
  input  crd_t              y,
  output logic              inside_scr,
  output logic [ADDR_W-1:0] addr
);
  logic [ADDR_W+CRD_W-1:0] prod;
  assign inside_scr = (x >= 0) && (y >= 0) && (x < crd_t'(SCREEN_COLUMNS))
                      && (y < crd_t'(SCREEN_ROWS));
  assign prod = (ADDR_W+CRD_W)'(y[CRD_W-2:0]) * (ADDR_W+CRD_W)'(SCREEN_COLUMNS)
                + (ADDR_W+CRD_W)'(x[CRD_W-2:0]);
  assign addr = prod[ADDR_W-1:0];
endmodule

[rtl/core/framebuffer_shape_draw_engine.sv]
// top level: command sequencer walking shapes one pixel per cycle
// Each command takes one item and returns one result item. Drawing runs one pixel
// per cycle through a shared plot unit and the single frame store port: a line walks
// line_length pixels, a fill (width x height), an outline its perimeter, a digit the
// outlines of its lit segments or, when solid, its box, and clear every address.
// A read registers the pixel in the store, then in the result. The block is not ready
// while a command runs or its result waits; reset does not clear the frame store.
module framebuffer_shape_draw_engine
  import fsde_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cmd, x_start, y_start, x_end, y_end, line_length, box_width, box_height,
  // stroke_width, digit, color (from bit 0 up)
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_value, clipped (from bit 0 up)
  output logic [15:0] m_tdata
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEG  = 3'd1;
  localparam logic [2:0] S_RECT = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_RWAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;

  // rect walk modes
  localparam logic [1:0] M_FILL = 2'd0;
  localparam logic [1:0] M_OUTL = 2'd1;

  logic [2:0] state;
  logic [1:0] mode;
  logic [1:0] phase;
  crd_t xs, xf, ys, yf, cx, cy;
  logic [2:0] segment_index;
  logic [6:0] mask;
  crd_t bx, by, bl, bh, bw, hh, vv;
  logic [7:0] pen;
  logic clip;
  logic [7:0] value;
  logic [ADDR_W-1:0] clr_addr;

  crd_t px, py;
  logic pvalid;
  logic ins;
  logic [ADDR_W-1:0] paddr;
  mem_req_t req;
  logic [7:0] rdata;

  fsde_plot u_plot (.x(px), .y(py), .inside_scr(ins), .addr(paddr));
  fsde_frame_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

  logic [2:0]  in_cmd;
  assign in_cmd = s_tdata[2:0];

  // current pixel of the walk
  always_comb begin
    px = cx;
    py = cy;
    pvalid = 1'b0;
    if (state == S_RECT) begin
      if (mode == M_FILL) begin
        pvalid = 1'b1;
      end else begin
        unique case (phase)
          2'd0: begin px = cx; py = (cy == 0) ? ys : yf; pvalid = cx < xf; end
          2'd1: begin px = (cx == 0) ? xs : xf; py = cy; pvalid = cy < yf; end
          default: begin px = xf; py = yf; pvalid = (xf >= xs) && (yf >= ys); end
        endcase
      end
    end else if (state == S_READ) begin
      pvalid = 1'b1;
    end
  end

  always_comb begin
    req.we = 1'b0;
    req.re = 1'b0;
    req.addr = paddr;
    req.data = pen;
    if (state == S_CLR) begin
      req.we = 1'b1;
      req.addr = clr_addr;
    end else if (state == S_RECT) begin
      req.we = pvalid && ins;
    end else if (state == S_READ) begin
      req.re = ins;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {7'd0, clip, value};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      segment_index <= '0;
      cx <= '0;
      cy <= '0;
      phase <= '0;
      clip <= 1'b0;
      value <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            pen <= s_tdata[80:73];
            clip <= 1'b0;
            value <= '0;
            xs <= crd_t'(s_tdata[10:3]);
            ys <= crd_t'(s_tdata[19:11]);
            mode <= M_FILL;
            phase <= '0;
            segment_index <= '0;
            bx <= crd_t'(s_tdata[10:3]);
            by <= crd_t'(s_tdata[19:11]);
            bl <= crd_t'(s_tdata[53:46]);
            bh <= crd_t'(s_tdata[62:54]);
            bw <= crd_t'(s_tdata[68:63]);
            hh <= crd_t'(s_tdata[62:55]);
            vv <= crd_t'(s_tdata[68:64]);
            mask <= seg_mask(s_tdata[72:69]);
            unique case (in_cmd)
              CMD_CLEAR: begin clr_addr <= '0; state <= S_CLR; end
              CMD_HLINE: begin
                xf <= crd_t'(s_tdata[10:3]) + crd_t'(s_tdata[45:37]) - crd_t'(1);
                yf <= crd_t'(s_tdata[19:11]);
                cx <= crd_t'(s_tdata[10:3]);
                cy <= crd_t'(s_tdata[19:11]);
                state <= (s_tdata[45:37] == 0) ? S_OUT : S_RECT;
              end
              CMD_VLINE: begin
                xf <= crd_t'(s_tdata[10:3]);
                yf <= crd_t'(s_tdata[19:11]) + crd_t'(s_tdata[45:37]) - crd_t'(1);
                cx <= crd_t'(s_tdata[10:3]);
                cy <= crd_t'(s_tdata[19:11]);
                state <= (s_tdata[45:37] == 0) ? S_OUT : S_RECT;
              end
              CMD_OUTLINE: begin
                xf <= crd_t'(s_tdata[27:20]);
                yf <= crd_t'(s_tdata[36:28]);
                cx <= crd_t'(s_tdata[10:3]);
                cy <= '0;
                mode <= M_OUTL;
                state <= S_RECT;
              end
              CMD_FILL: begin
                xf <= crd_t'(s_tdata[27:20]);
                yf <= crd_t'(s_tdata[36:28]);
                cx <= crd_t'(s_tdata[10:3]);
                cy <= crd_t'(s_tdata[19:11]);
                state <= ((s_tdata[27:20] >= s_tdata[10:3]) &&
                          (s_tdata[36:28] >= s_tdata[19:11])) ? S_RECT : S_OUT;
              end
              CMD_DIGIT: begin
                if (s_tdata[72:69] == DIGIT_SOLID) begin
                  xf <= crd_t'(s_tdata[10:3]) + crd_t'(s_tdata[53:46]);
                  yf <= crd_t'(s_tdata[19:11]) + crd_t'(s_tdata[62:54]);
                  cx <= crd_t'(s_tdata[10:3]);
                  cy <= crd_t'(s_tdata[19:11]);
                  state <= S_RECT;
                end else begin
                  state <= S_SEG;
                end
              end
              CMD_READ: begin
                cx <= crd_t'(s_tdata[10:3]);
                cy <= crd_t'(s_tdata[19:11]);
                state <= S_READ;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(FRAME_SIZE - 1)) begin
            state <= S_OUT;
          end
        end
        S_SEG: begin
          if (segment_index == 3'd7) begin
            segment_index <= '0;
            state <= S_OUT;
          end else begin
            segment_index <= segment_index + 1'b1;
            if (mask[segment_index]) begin
              mode <= M_OUTL;
              phase <= '0;
              cy <= '0;
              state <= S_RECT;
              unique case (segment_index)
                3'd0: begin
                  xs <= bx + crd_t'(SEGMENT_PADDING) + bw;
                  xf <= bx + bl - crd_t'(SEGMENT_PADDING) - bw;
                  ys <= by; yf <= by + bw;
                  cx <= bx + crd_t'(SEGMENT_PADDING) + bw;
                end
                3'd1: begin
                  xs <= bx + bl - crd_t'(SEGMENT_PADDING) - bw;
                  xf <= bx + bl - crd_t'(SEGMENT_PADDING);
                  ys <= by + bw; yf <= by + hh - vv;
                  cx <= bx + bl - crd_t'(SEGMENT_PADDING) - bw;
                end
                3'd2: begin
                  xs <= bx + bl - crd_t'(SEGMENT_PADDING) - bw;
                  xf <= bx + bl - crd_t'(SEGMENT_PADDING);
                  ys <= by + hh + vv; yf <= by + bh - bw;
                  cx <= bx + bl - crd_t'(SEGMENT_PADDING) - bw;
                end
                3'd3: begin
                  xs <= bx + crd_t'(SEGMENT_PADDING) + bw;
                  xf <= bx + bl - crd_t'(SEGMENT_PADDING) - bw;
                  ys <= by + bh - bw; yf <= by + bh;
                  cx <= bx + crd_t'(SEGMENT_PADDING) + bw;
                end
                3'd4: begin
                  xs <= bx + crd_t'(SEGMENT_PADDING);
                  xf <= bx + crd_t'(SEGMENT_PADDING) + bw;
                  ys <= by + hh + vv; yf <= by + bh - bw;
                  cx <= bx + crd_t'(SEGMENT_PADDING);
                end
                3'd5: begin
                  xs <= bx + crd_t'(SEGMENT_PADDING);
                  xf <= bx + crd_t'(SEGMENT_PADDING) + bw;
                  ys <= by + bw; yf <= by + hh - vv;
                  cx <= bx + crd_t'(SEGMENT_PADDING);
                end
                default: begin
                  xs <= bx + crd_t'(SEGMENT_PADDING) + bw;
                  xf <= bx + bl - crd_t'(SEGMENT_PADDING) - bw;
                  ys <= by + hh - vv; yf <= by + hh + vv;
                  cx <= bx + crd_t'(SEGMENT_PADDING) + bw;
                end
              endcase
            end
          end
        end
        S_RECT: begin
          if (pvalid && !ins) begin
            clip <= 1'b1;
          end
          if (mode == M_FILL) begin
            if (cx >= xf) begin
              cx <= xs;
              if (cy >= yf) begin
                state <= S_OUT;
              end else begin
                cy <= cy + crd_t'(1);
              end
            end else begin
              cx <= cx + crd_t'(1);
            end
          end else begin
            // outline: phase 0 top/bottom rows, 1 side columns, 2 corner
            unique case (phase)
              2'd0: begin
                if (cy == 0) begin
                  cy <= crd_t'(1);
                end else begin
                  cy <= '0;
                  if (cx + crd_t'(1) >= xf) begin
                    phase <= 2'd1;
                    cx <= '0;
                    cy <= ys;
                  end else begin
                    cx <= cx + crd_t'(1);
                  end
                end
                if (!(cx < xf)) begin
                  phase <= 2'd1;
                  cx <= '0;
                  cy <= ys;
                end
              end
              2'd1: begin
                if (!(cy < yf)) begin
                  phase <= 2'd2;
                end else if (cx == 0) begin
                  cx <= crd_t'(1);
                end else begin
                  cx <= '0;
                  if (cy + crd_t'(1) >= yf) begin
                    phase <= 2'd2;
                  end else begin
                    cy <= cy + crd_t'(1);
                  end
                end
              end
              default: begin
                phase <= '0;
                state <= (mask != 7'd0 && segment_index != 3'd0) ? S_SEG : S_OUT;
              end
            endcase
          end
        end
        S_READ: begin
          if (!ins) begin
            clip <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_RWAIT;
          end
        end
        S_RWAIT: begin
          value <= rdata;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
            segment_index <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/fsde_checker.sv]
// port checker for the draw engine and its bind
module fsde_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("ready while result pending");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("ready right after accept");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:9] == 7'd0) else $error("pad bits set");
endmodule

bind framebuffer_shape_draw_engine fsde_checker u_fsde_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
